### rtl/kect_pkg.sv
// Package with the shared codes and item types of the keyed event counter table.
package kect_pkg;

	typedef enum logic [1:0] {
		FN_COUNT = 2'd0,
		FN_PRUNE = 2'd1,
		FN_QUERY = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	localparam int KEY_W = 32;
	localparam int HITS_W = 16;
	localparam int CNT_OUT_W = 7;
	localparam logic [HITS_W-1:0] HITS_MAX = '1;

	typedef struct packed {
		func_t func;
		logic [KEY_W-1:0] key;
		logic [HITS_W-1:0] threshold;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [HITS_W-1:0] hits;
	} entry_t;

endpackage

### rtl/kect_in_if.sv
// Input channel of the keyed event counter table.
interface kect_in_if;
	import kect_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [KEY_W-1:0] key;
	logic [HITS_W-1:0] threshold;
	modport source (output valid, output func, output key, output threshold, input ready);
	modport sink (input valid, input func, input key, input threshold, output ready);
endinterface

### rtl/kect_out_if.sv
// Result channel of the keyed event counter table.
interface kect_out_if;
	import kect_pkg::*;
	logic valid;
	logic ready;
	logic [KEY_W-1:0] best_key;
	logic [HITS_W-1:0] best_count;
	logic [CNT_OUT_W-1:0] entry_count;
	logic status;
	modport source (output valid, output best_key, output best_count, output entry_count,
		output status, input ready);
	modport sink (input valid, input best_key, input best_count, input entry_count,
		input status, output ready);
endinterface

### rtl/keyed_event_counter_table_top.sv
// Top level of the keyed event counter table.
//
// Items enter on in_ch (func, key, threshold) with a valid/ready handshake and
// each produces exactly one result on out_ch (best_key, best_count,
// entry_count, status). A front end classifies items into a two-entry queue,
// so up to two items are taken while the back end is busy or a result waits.
// The back end reads every table entry once from a RAM, one entry per cycle,
// removing pruned entries and tracking the best key in the same pass, and
// then writes the new or incremented count back. Each item passes from the
// queue through the scan, drain and finish states to its result, one at a
// time. A result is held until out_ch.ready is high; while it waits, the
// back end takes no new item and the queue fills.
// Reset empties the table at once by clearing the per-entry valid bits; the
// RAM contents are not cleared.
module keyed_event_counter_table_top import kect_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	kect_in_if.sink in_ch,
	kect_out_if.source out_ch
);
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	kect_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	kect_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop), .out_ch(out_ch)
	);
endmodule

### rtl/kect_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kect_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/kect_front.sv
// Front end: accepts and classifies items into a two-entry command queue.
module kect_front import kect_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	kect_in_if.sink in_ch,
	output logic  q_valid,
	output cmd_t  q_cmd,
	input  logic  q_pop
);
	cmd_t       buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;

	always_comb begin
		cls.func = func_t'(in_ch.func);
		cls.key = in_ch.key;
		cls.threshold = in_ch.threshold;
		if (cls.func == FN_PRUNE && in_ch.threshold == '0) begin
			cls.func = FN_QUERY;
		end
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

### rtl/kect_back.sv
// Back end: scans the table once per command, updates it and finds the best key.
module kect_back import kect_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic q_pop,
	kect_out_if.source out_ch
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN, S_OUT} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic [IW-1:0]            cnt_q;
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic                     rd_s1;
	logic [IW-1:0]            idx_s1;
	logic                     v_s1;
	logic                     match_q;
	logic [IW-1:0]            midx_q;
	logic [HITS_W-1:0]        mhits_q;
	logic                     free_q;
	logic [IW-1:0]            fidx_q;
	logic [CW-1:0]            used_q;
	logic                     found_q;
	logic [KEY_W-1:0]         bk_q;
	logic [HITS_W-1:0]        bc_q;
	logic                     status_q;

	entry_t            rdata;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	entry_t            ram_wdata;
	logic              is_match;
	logic              live;
	logic [HITS_W-1:0] eff;
	logic              better;
	logic              new_better;
	logic [HITS_W-1:0] mhits_inc;

	kect_ram #(.WIDTH(KEY_W + HITS_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(cnt_q), .rdata(rdata)
	);

	assign mhits_inc = (mhits_q == HITS_MAX) ? mhits_q : mhits_q + 1'b1;

	always_comb begin
		is_match = v_s1 && cmd_q.func == FN_COUNT && rdata.key == cmd_q.key;
		live = v_s1 && !(cmd_q.func == FN_PRUNE && rdata.hits < cmd_q.threshold);
		eff = rdata.hits;
		if (is_match && rdata.hits != HITS_MAX) begin
			eff = rdata.hits + 1'b1;
		end
		better = !found_q || eff > bc_q || (eff == bc_q && rdata.key > bk_q);
		new_better = !found_q || bc_q < HITS_W'(1)
			|| (bc_q == HITS_W'(1) && cmd_q.key > bk_q);
		ram_we = 1'b0;
		ram_waddr = midx_q;
		ram_wdata.key = cmd_q.key;
		ram_wdata.hits = mhits_inc;
		if (state_q == S_FIN && cmd_q.func == FN_COUNT) begin
			if (match_q) begin
				ram_we = 1'b1;
			end else if (free_q) begin
				ram_we = 1'b1;
				ram_waddr = fidx_q;
				ram_wdata.hits = HITS_W'(1);
			end
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.best_key = bk_q;
	assign out_ch.best_count = bc_q;
	assign out_ch.entry_count = CNT_OUT_W'(used_q);
	assign out_ch.status = status_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= cnt_q;
			v_s1 <= vld_q[cnt_q];
		end
		if (rd_s1 && is_match) begin
			midx_q <= idx_s1;
			mhits_q <= rdata.hits;
		end
		if (rd_s1 && !v_s1 && !free_q) begin
			fidx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			vld_q <= '0;
			rd_s1 <= 1'b0;
			match_q <= 1'b0;
			free_q <= 1'b0;
			used_q <= '0;
			found_q <= 1'b0;
			bk_q <= '0;
			bc_q <= '0;
			status_q <= 1'b0;
		end else begin
			if (rd_s1) begin
				if (is_match) begin
					match_q <= 1'b1;
				end
				if (!v_s1) begin
					free_q <= 1'b1;
				end
				if (v_s1 && !live) begin
					vld_q[idx_s1] <= 1'b0;
				end
				if (live) begin
					used_q <= used_q + 1'b1;
					if (better) begin
						found_q <= 1'b1;
						bk_q <= rdata.key;
						bc_q <= eff;
					end
				end
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_cmd.func == FN_CLEAR) begin
							vld_q <= '0;
						end
						cnt_q <= '0;
						match_q <= 1'b0;
						free_q <= 1'b0;
						used_q <= '0;
						found_q <= 1'b0;
						bk_q <= '0;
						bc_q <= '0;
						status_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_s1 <= 1'b1;
					if (cnt_q == LAST) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					rd_s1 <= 1'b0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (cmd_q.func == FN_COUNT && !match_q) begin
						if (free_q) begin
							vld_q[fidx_q] <= 1'b1;
							used_q <= used_q + 1'b1;
							if (new_better) begin
								found_q <= 1'b1;
								bk_q <= cmd_q.key;
								bc_q <= HITS_W'(1);
							end
						end else begin
							status_q <= 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
